/* rtl/core/lrmp_pkg.sv */
// Shared constants and types for the linear recurrence term block.
// No dependencies; used by lrmp_modmac and linear_recurrence_matrix_power_mod.
package lrmp_pkg;

    // Field widths
    localparam int ValW  = 30;
    localparam int IdxW  = 31;
    localparam int EntW  = 4;   // entry index inside a 3x3 matrix (0..8)
    localparam int BankW = 2;   // matrix bank select

    // Prime modulus and Barrett constant floor(2^60 / P)
    localparam logic [29:0] Modulus   = 30'd1000000007;
    localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'd1000000007);

    // Indices at or below this return 1 directly
    localparam logic [30:0] BaseTerms = 31'd3;

    // Entry masks, bit n is entry (row*3 + col)
    localparam logic [8:0] CompMask = 9'b010_001_101;   // companion matrix
    localparam logic [8:0] IdMask   = 9'b100_010_001;   // identity matrix

    // Tag that travels with each term through the multiply-accumulate pipe
    typedef struct packed {
        logic            first;   // start a new sum with this term
        logic            last;    // emit the sum after this term
        logic [EntW-1:0] idx;     // destination entry of the sum
    } t_mac_tag;

endpackage

/* rtl/core/lrmp_ram.sv */
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
module lrmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]         o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* rtl/core/lrmp_modmac.sv */
// Pipelined modular multiply-accumulate: sum of a*b mod P over tagged terms.
// Five stages: product, two Barrett multiplies, correction, accumulate.
// Depends on lrmp_pkg.
module lrmp_modmac (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [29:0]              i_a,
    input  logic [29:0]              i_b,
    input  lrmp_pkg::t_mac_tag       i_tag,
    output logic                     o_valid,
    output logic [29:0]              o_value,
    output logic [lrmp_pkg::EntW-1:0] o_idx,
    output logic                     o_busy
);

    localparam logic [31:0] OneP = {2'b00, lrmp_pkg::Modulus};
    localparam logic [31:0] TwoP = {1'b0, lrmp_pkg::Modulus, 1'b0};

    // Stage valids and tags
    logic               r_v1, r_v2, r_v3, r_v4, r_out_valid;
    lrmp_pkg::t_mac_tag r_tag1, r_tag2, r_tag3, r_tag4;
    logic [lrmp_pkg::EntW-1:0] r_out_idx;

    // Data path registers
    logic [59:0] r_x;
    logic [61:0] r_q2;
    logic [31:0] r_xlo2;
    logic [31:0] r_xlo3;
    logic [31:0] r_t;
    logic [29:0] r_r;
    logic [29:0] r_acc;

    logic [59:0] prod_x;
    logic [61:0] prod_q2;
    logic [60:0] prod_t;
    logic [31:0] diff;
    logic [29:0] n_r;
    logic [29:0] acc_base;
    logic [30:0] acc_sum;
    logic [29:0] n_acc;

    // Product, quotient estimate and quotient times modulus
    assign prod_x  = {30'd0, i_a} * {30'd0, i_b};
    assign prod_q2 = {31'd0, r_x[59:29]} * {31'd0, lrmp_pkg::BarrettMu};
    assign prod_t  = {30'd0, r_q2[61:31]} * {31'd0, lrmp_pkg::Modulus};

    // Remainder is below 3P, so the low 32 bits carry it exactly
    assign diff = r_xlo3 - r_t;
    always_comb begin
        if (diff >= TwoP) begin
            n_r = 30'(diff - TwoP);
        end else if (diff >= OneP) begin
            n_r = 30'(diff - OneP);
        end else begin
            n_r = diff[29:0];
        end
    end

    // Add the reduced term into the running sum
    assign acc_base = r_tag4.first ? 30'd0 : r_acc;
    assign acc_sum  = {1'b0, acc_base} + {1'b0, r_r};
    assign n_acc    = (acc_sum >= {1'b0, lrmp_pkg::Modulus})
                    ? 30'(acc_sum - {1'b0, lrmp_pkg::Modulus}) : acc_sum[29:0];

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4 && r_tag4.last;
        end
    end

    // Advance data and tags
    always_ff @(posedge i_clk) begin
        r_x    <= prod_x;
        r_tag1 <= i_tag;
        r_q2   <= prod_q2;
        r_xlo2 <= r_x[31:0];
        r_tag2 <= r_tag1;
        r_t    <= prod_t[31:0];
        r_xlo3 <= r_xlo2;
        r_tag3 <= r_tag2;
        r_r    <= n_r;
        r_tag4 <= r_tag3;
        if (r_v4) begin
            r_acc     <= n_acc;
            r_out_idx <= r_tag4.idx;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_acc;
    assign o_idx   = r_out_idx;
    assign o_busy  = r_v1 || r_v2 || r_v3 || r_v4 || r_out_valid;

endmodule

/* rtl/core/linear_recurrence_matrix_power_mod.sv */
// Term n of a(x) = a(x-1) + a(x-3), a(1..3) = 1, modulo 1000000007, computed by
// square-and-multiply of the 3x3 companion matrix. Index <= 3: result 1 via S_PUT, no products.
// Otherwise each matrix product has a setup state, 27 terms issued through the shared
// modular multiply-accumulate pipe and a drain; one product per set exponent bit plus one
// squaring per higher bit, then a row sum of the first row. One item at a time:
// the next index is accepted the cycle after the result is loaded.
// Synchronous active-low reset clears control state; matrix RAM is never read before written.
// Depends on lrmp_pkg, lrmp_ram, lrmp_modmac.
module linear_recurrence_matrix_power_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [30:0] i_term_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [29:0] o_term_value
);

    localparam int RamDepth = 3 * 16;
    localparam int AddrW    = $clog2(RamDepth);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BIT   = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;

    // Matrix operations
    localparam logic [1:0] OP_ACC = 2'd0;   // acc = acc * sq
    localparam logic [1:0] OP_SQ  = 2'd1;   // sq  = sq * sq
    localparam logic [1:0] OP_ROW = 2'd2;   // sum of the first row of acc

    logic [2:0]  r_state;
    logic [1:0]  r_op;
    logic [30:0] r_exp;
    logic [lrmp_pkg::BankW-1:0] r_ab_bank, r_sb_bank, r_dst_bank;
    logic        r_ab_virt, r_sb_virt;    // matrix is still the identity / companion
    logic [1:0]  r_i, r_j, r_k;
    logic [29:0] r_result;
    logic        r_out_valid;
    logic [29:0] r_out_value;

    // Read stage registers
    logic               r_rd_valid;
    lrmp_pkg::t_mac_tag r_rd_tag;
    logic               r_a_virt, r_a_one, r_b_virt, r_b_one;

    logic [2:0]  used;
    logic [lrmp_pkg::BankW-1:0] free_bank;
    logic [lrmp_pkg::EntW-1:0]  i3, k3, a_idx, b_idx, dst_idx;
    logic [lrmp_pkg::BankW-1:0] a_bank, b_bank;
    logic        a_virt, b_virt;
    logic [8:0]  a_mask, b_mask;
    logic        issue_last;
    lrmp_pkg::t_mac_tag issue_tag;

    logic [29:0] rd_a, rd_b;
    logic [29:0] mac_a, mac_b;
    logic        mac_out_valid, mac_busy;
    logic [29:0] mac_value;
    logic [lrmp_pkg::EntW-1:0] mac_idx;
    logic        wr_en;

    // Pick a bank that holds neither live matrix
    always_comb begin
        used = 3'b000;
        if (!r_ab_virt) begin
            used[r_ab_bank] = 1'b1;
        end
        if (!r_sb_virt) begin
            used[r_sb_bank] = 1'b1;
        end
        if (!used[0]) begin
            free_bank = 2'd0;
        end else if (!used[1]) begin
            free_bank = 2'd1;
        end else begin
            free_bank = 2'd2;
        end
    end

    // Entry indices of the current term
    assign i3      = 4'({2'b00, r_i} << 1) + {2'b00, r_i};
    assign k3      = 4'({2'b00, r_k} << 1) + {2'b00, r_k};
    assign a_idx   = i3 + {2'b00, r_k};
    assign b_idx   = k3 + {2'b00, r_j};
    assign dst_idx = i3 + {2'b00, r_j};

    // Route operands from RAM banks or fixed matrices
    always_comb begin
        case (r_op)
            OP_ACC: begin
                a_bank = r_ab_bank;  a_virt = r_ab_virt;  a_mask = lrmp_pkg::IdMask;
                b_bank = r_sb_bank;  b_virt = r_sb_virt;  b_mask = lrmp_pkg::CompMask;
            end
            OP_SQ: begin
                a_bank = r_sb_bank;  a_virt = r_sb_virt;  a_mask = lrmp_pkg::CompMask;
                b_bank = r_sb_bank;  b_virt = r_sb_virt;  b_mask = lrmp_pkg::CompMask;
            end
            default: begin
                a_bank = r_ab_bank;  a_virt = r_ab_virt;  a_mask = lrmp_pkg::IdMask;
                b_bank = r_sb_bank;  b_virt = 1'b1;       b_mask = 9'h1ff;
            end
        endcase
    end

    assign issue_last = (r_op == OP_ROW) ? (r_k == 2'd2)
                      : (r_i == 2'd2 && r_j == 2'd2 && r_k == 2'd2);
    assign issue_tag.first = (r_k == 2'd0);
    assign issue_tag.last  = (r_k == 2'd2);
    assign issue_tag.idx   = dst_idx;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_ROW;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ab_virt   <= 1'b1;
            r_sb_virt   <= 1'b1;
            r_ab_bank   <= 2'd0;
            r_sb_bank   <= 2'd0;
            r_dst_bank  <= 2'd0;
        end else begin
            // drop the output item once taken
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            r_rd_valid <= (r_state == S_ISSUE);
            if (mac_out_valid && r_op == OP_ROW) begin
                r_result <= mac_value;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_term_index <= lrmp_pkg::BaseTerms) begin
                            r_result <= 30'd1;
                            r_state  <= S_PUT;
                        end else begin
                            r_exp     <= i_term_index - lrmp_pkg::BaseTerms;
                            r_ab_virt <= 1'b1;
                            r_sb_virt <= 1'b1;
                            r_state   <= S_BIT;
                        end
                    end
                end
                S_BIT: begin
                    r_i        <= 2'd0;
                    r_j        <= 2'd0;
                    r_k        <= 2'd0;
                    r_dst_bank <= free_bank;
                    if (r_exp == 31'd0) begin
                        r_op <= OP_ROW;
                    end else if (r_exp[0]) begin
                        r_op <= OP_ACC;
                    end else begin
                        r_op <= OP_SQ;
                    end
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    // advance k, then j, then i
                    if (r_k == 2'd2) begin
                        r_k <= 2'd0;
                        if (r_j == 2'd2) begin
                            r_j <= 2'd0;
                            r_i <= r_i + 2'd1;
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                    if (issue_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_valid && !mac_busy) begin
                        case (r_op)
                            OP_ACC: begin
                                r_ab_bank <= r_dst_bank;
                                r_ab_virt <= 1'b0;
                                r_exp[0]  <= 1'b0;
                                r_state   <= S_BIT;
                            end
                            OP_SQ: begin
                                r_sb_bank <= r_dst_bank;
                                r_sb_virt <= 1'b0;
                                r_exp     <= r_exp >> 1;
                                r_state   <= S_BIT;
                            end
                            default: begin
                                r_state <= S_PUT;
                            end
                        endcase
                    end
                end
                S_PUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_result;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Hold operand source flags alongside the RAM read
    always_ff @(posedge i_clk) begin
        r_rd_tag <= issue_tag;
        r_a_virt <= a_virt;
        r_a_one  <= a_mask[a_idx];
        r_b_virt <= b_virt;
        r_b_one  <= b_mask[b_idx];
    end

    assign wr_en = mac_out_valid && (r_op != OP_ROW);

    lrmp_ram #(
        .WIDTH (30),
        .DEPTH (RamDepth)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (AddrW'({r_dst_bank, mac_idx})),
        .i_wr_data   (mac_value),
        .i_rd_addr_a (AddrW'({a_bank, a_idx})),
        .o_rd_data_a (rd_a),
        .i_rd_addr_b (AddrW'({b_bank, b_idx})),
        .o_rd_data_b (rd_b)
    );

    assign mac_a = r_a_virt ? {29'd0, r_a_one} : rd_a;
    assign mac_b = r_b_virt ? {29'd0, r_b_one} : rd_b;

    lrmp_modmac u_modmac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_tag   (r_rd_tag),
        .o_valid (mac_out_valid),
        .o_value (mac_value),
        .o_idx   (mac_idx),
        .o_busy  (mac_busy)
    );

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_term_value = r_out_value;

    // A product never overwrites a matrix it still reads
    a_dst_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_ab_virt || r_dst_bank != r_ab_bank)
                && (r_sb_virt || r_dst_bank != r_sb_bank)))
        else $error("matrix write hits a live bank");

    // A new operation starts only with the pipe empty
    a_bit_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT) |-> (!r_rd_valid && !mac_busy))
        else $error("operation started with terms in flight");

    // The row sum arrives only while draining
    a_row_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mac_out_valid && r_op == OP_ROW) |-> (r_state == S_DRAIN))
        else $error("row sum outside drain");

    // Matrix products run only on a nonzero exponent
    a_exp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE && r_op != OP_ROW) |-> (r_exp != 31'd0))
        else $error("matrix product with zero exponent");

    // Results stay reduced
    a_out_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_term_value < lrmp_pkg::Modulus))
        else $error("result not reduced");

endmodule
